FILE: src/printable_run_extractor_macros.svh
// Assertion macros for the printable run extractor.
`ifndef PRINTABLE_RUN_EXTRACTOR_MACROS_SVH
`define PRINTABLE_RUN_EXTRACTOR_MACROS_SVH
`ifndef SYNTHESIS
`define PRE_ASSERT_CLK(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("assertion failed");
`define PRE_ASSERT(lbl, prop) `PRE_ASSERT_CLK(lbl, clk_i, rst_ni, prop)
`else
`define PRE_ASSERT_CLK(lbl, clk, rstn, prop)
`define PRE_ASSERT(lbl, prop)
`endif
`endif

FILE: src/pre_pkg.sv
// Shared types and constants of the printable run extractor.
package pre_pkg;

  localparam int unsigned MaxMinLengthDef = 16;
  localparam int unsigned MinLenW = 5;
  localparam logic [MinLenW-1:0] MinLenReset = 5'd4;
  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned CfgDataW = 5;
  localparam int unsigned CmdQDepth = 2;

  localparam logic [CfgIdxW-1:0] RegMinLength = 1'b0;
  localparam logic [CfgIdxW-1:0] RegWideMode = 1'b1;

  localparam logic [7:0] PrintLo = 8'h20;
  localparam logic [7:0] PrintHi = 8'h7E;
  localparam logic [7:0] TabChar = 8'h09;

  typedef enum logic {
    KindChar = 1'b0,
    KindEnd  = 1'b1
  } kind_e;

  typedef struct packed {
    logic       has_char;
    logic       do_close;
    logic [7:0] ch;
  } cmd_t;

  typedef struct packed {
    logic                we;
    logic [CfgIdxW-1:0]  idx;
    logic [CfgDataW-1:0] data;
  } cfg_wr_t;

endpackage

FILE: src/pre_front.sv
// Front end: accepts bytes, pairs them in wide mode and classifies them into commands.
module pre_front import pre_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cfg_wr_t    cfg_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] byte_i,
  input  logic       eod_i,
  input  logic       q_full_i,
  output logic       cmd_push_o,
  output cmd_t       cmd_o
);

  logic       wide_q, wide_d;
  logic       phase_q, phase_d;
  logic [7:0] low_q, low_d;
  logic       accept;
  logic       byte_ok;
  logic       pair_ok;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign byte_ok    = ((byte_i >= PrintLo) && (byte_i <= PrintHi)) || (byte_i == TabChar);
  assign pair_ok    = (byte_i == 8'h00) && (low_q >= PrintLo) && (low_q <= PrintHi);

  always_comb begin
    wide_d         = wide_q;
    phase_d        = phase_q;
    low_d          = low_q;
    cmd_o.has_char = 1'b0;
    cmd_o.do_close = 1'b0;
    cmd_o.ch       = byte_i;
    if (!wide_q) begin
      cmd_o.has_char = byte_ok;
      cmd_o.do_close = !byte_ok;
    end else if (!phase_q) begin
      phase_d = 1'b1;
      low_d   = byte_i;
    end else begin
      phase_d        = 1'b0;
      cmd_o.has_char = pair_ok;
      cmd_o.do_close = !pair_ok;
      cmd_o.ch       = low_q;
    end
    if (eod_i) begin
      cmd_o.do_close = 1'b1;
      phase_d        = 1'b0;
    end
    if (!accept) begin
      phase_d = phase_q;
      low_d   = low_q;
    end
    if (cfg_i.we) begin
      case (cfg_i.idx)
        RegWideMode: begin
          wide_d  = cfg_i.data[0];
          phase_d = 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  assign cmd_push_o = accept && (cmd_o.has_char || cmd_o.do_close);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wide_q  <= 1'b0;
      phase_q <= 1'b0;
      low_q   <= 8'h00;
    end else begin
      wide_q  <= wide_d;
      phase_q <= phase_d;
      low_q   <= low_d;
    end
  end

endmodule

FILE: src/pre_cmd_fifo.sv
// Short command queue between the front end and the back end.
module pre_cmd_fifo import pre_pkg::*; #(
  parameter int unsigned Depth = CmdQDepth
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t data_i,
  output logic full_o,
  input  logic pop_i,
  output cmd_t data_o,
  output logic empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  cmd_t            entries_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push;
  logic            do_pop;

  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = entries_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

FILE: src/pre_back.sv
// Back end: tracks the run, holds early characters and emits characters and end markers.
`include "printable_run_extractor_macros.svh"
module pre_back import pre_pkg::*; #(
  parameter int unsigned MAX_MIN_LENGTH = MaxMinLengthDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cfg_wr_t    cfg_i,
  input  logic       q_empty_i,
  output logic       q_pop_o,
  input  cmd_t       cmd_i,
  output logic       m_valid_o,
  input  logic       m_ready_i,
  output kind_e      m_kind_o,
  output logic [7:0] m_char_o,
  output logic       m_last_o
);

  localparam int unsigned Depth = MAX_MIN_LENGTH - 1;
  localparam int unsigned LW = $clog2(MAX_MIN_LENGTH);
  localparam int unsigned HW = (MAX_MIN_LENGTH > 2) ? $clog2(MAX_MIN_LENGTH - 1) : 1;
  localparam int unsigned MW = $clog2(MAX_MIN_LENGTH + 1);
  localparam int unsigned CW = (MW > MinLenW) ? MW : MinLenW;

  typedef enum logic [4:0] {
    SIdle  = 5'b00001,
    SRead  = 5'b00010,
    SDrain = 5'b00100,
    SChar  = 5'b01000,
    SMark  = 5'b10000
  } state_e;

  state_e             state_q, state_d;
  logic [MinLenW-1:0] min_len_q, min_len_d;
  logic [LW-1:0]      run_len_q, run_len_d;
  logic               open_q, open_d;
  logic [LW-1:0]      cnt_q, cnt_d;
  logic [LW-1:0]      idx_q, idx_d;
  logic               emit_ch_q, emit_ch_d;
  logic               mark_q, mark_d;
  logic [7:0]         ch_q, ch_d;
  logic [7:0]         held_q [Depth];
  logic [7:0]         rdata_q;

  logic               out_valid_q, out_valid_d;
  kind_e              out_kind_q, out_kind_d;
  logic [7:0]         out_char_q, out_char_d;
  logic               out_last_q, out_last_d;
  logic               out_load;
  logic               out_free;

  logic [CW-1:0]      min_ext;
  logic [CW-1:0]      eff_min;
  logic [CW-1:0]      len0;
  logic [CW-1:0]      len1;
  logic               char_emit;
  logic               flush;
  logic               stored;
  logic               marker;

  assign min_ext = CW'(min_len_q);
  assign eff_min = (min_len_q == '0) ? CW'(1) :
                   ((min_ext > CW'(MAX_MIN_LENGTH)) ? CW'(MAX_MIN_LENGTH) : min_ext);
  assign len0    = CW'(run_len_q);
  assign len1    = CW'(run_len_q) + CW'(1);

  assign char_emit = cmd_i.has_char && (open_q || (len1 >= eff_min));
  assign flush     = !open_q && (cmd_i.has_char ? (len1 >= eff_min)
                                                : (cmd_i.do_close && (len0 >= eff_min)));
  assign stored    = cmd_i.has_char && !char_emit;
  assign marker    = cmd_i.do_close && (open_q || char_emit || flush);
  assign out_free  = !out_valid_q || m_ready_i;

  always_comb begin
    state_d     = state_q;
    min_len_d   = min_len_q;
    run_len_d   = run_len_q;
    open_d      = open_q;
    cnt_d       = cnt_q;
    idx_d       = idx_q;
    emit_ch_d   = emit_ch_q;
    mark_d      = mark_q;
    ch_d        = ch_q;
    q_pop_o     = 1'b0;
    out_load    = 1'b0;
    out_kind_d  = KindChar;
    out_char_d  = 8'h00;
    out_last_d  = 1'b0;
    case (state_q)
      SIdle: begin
        if (!q_empty_i) begin
          q_pop_o   = 1'b1;
          ch_d      = cmd_i.ch;
          emit_ch_d = char_emit;
          mark_d    = marker;
          cnt_d     = run_len_q;
          idx_d     = '0;
          if (stored) begin
            run_len_d = run_len_q + LW'(1);
          end
          if (flush || cmd_i.do_close) begin
            run_len_d = '0;
          end
          if (cmd_i.do_close) begin
            open_d = 1'b0;
          end else if (char_emit) begin
            open_d = 1'b1;
          end
          if (flush && (run_len_q != '0)) begin
            state_d = SRead;
          end else if (char_emit) begin
            state_d = SChar;
          end else if (marker) begin
            state_d = SMark;
          end
        end
      end
      SRead: begin
        state_d = SDrain;
      end
      SDrain: begin
        if (out_free) begin
          out_load   = 1'b1;
          out_kind_d = KindChar;
          out_char_d = rdata_q;
          out_last_d = (idx_q == cnt_q - LW'(1)) && !emit_ch_q && !mark_q;
          idx_d      = idx_q + LW'(1);
          if (idx_q == cnt_q - LW'(1)) begin
            state_d = emit_ch_q ? SChar : (mark_q ? SMark : SIdle);
          end else begin
            state_d = SRead;
          end
        end
      end
      SChar: begin
        if (out_free) begin
          out_load   = 1'b1;
          out_kind_d = KindChar;
          out_char_d = ch_q;
          out_last_d = !mark_q;
          state_d    = mark_q ? SMark : SIdle;
        end
      end
      SMark: begin
        if (out_free) begin
          out_load   = 1'b1;
          out_kind_d = KindEnd;
          out_char_d = 8'h00;
          out_last_d = 1'b1;
          state_d    = SIdle;
        end
      end
      default: begin
        state_d = SIdle;
      end
    endcase
    if (cfg_i.we) begin
      case (cfg_i.idx)
        RegMinLength: min_len_d = cfg_i.data[MinLenW-1:0];
        default: begin
        end
      endcase
    end
  end

  assign out_valid_d = out_load || (out_valid_q && !m_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SIdle;
      min_len_q   <= MinLenReset;
      run_len_q   <= '0;
      open_q      <= 1'b0;
      cnt_q       <= '0;
      idx_q       <= '0;
      emit_ch_q   <= 1'b0;
      mark_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      min_len_q   <= min_len_d;
      run_len_q   <= run_len_d;
      open_q      <= open_d;
      cnt_q       <= cnt_d;
      idx_q       <= idx_d;
      emit_ch_q   <= emit_ch_d;
      mark_q      <= mark_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ch_q <= ch_d;
    if (out_load) begin
      out_kind_q <= out_kind_d;
      out_char_q <= out_char_d;
      out_last_q <= out_last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o && stored) begin
      held_q[run_len_q[HW-1:0]] <= cmd_i.ch;
    end
    if (state_q == SRead) begin
      rdata_q <= held_q[idx_q[HW-1:0]];
    end
  end

  assign m_valid_o = out_valid_q;
  assign m_kind_o  = out_kind_q;
  assign m_char_o  = out_char_q;
  assign m_last_o  = out_last_q;

  `PRE_ASSERT(a_end_closes_run, (out_load && (out_kind_d == KindEnd)) |-> !open_q)
  `PRE_ASSERT(a_drain_in_range, (state_q == SDrain) |-> (idx_q < cnt_q))
  `PRE_ASSERT(a_hold_grows, (q_pop_o && stored && !cmd_i.do_close) |=>
              (run_len_q == $past(run_len_q) + LW'(1)))

endmodule

FILE: src/printable_run_extractor.sv
// Top level of the printable run extractor: front end, command queue and back end.
//
// Channel   Dir  Handshake                      Payload
// s_axis    in   s_axis_tvalid / s_axis_tready  tdata = byte_value, tlast = end_of_data
// m_axis    out  m_axis_tvalid / m_axis_tready  tdata = character, tuser = kind,
//                                               tlast = last_of_item
// cfg       in   cfg_we_i                       cfg_idx_i, cfg_data_i
//
// The front end takes one byte per cycle while the command queue has room.
// The back end decodes each command in SIdle, emits a direct character in SChar or an end
// marker in SMark, and releases each held character through SRead (held memory read), then
// SDrain (output register); it pops the next command only once it is back in SIdle.
// Reset clears all control state; the held-character memory is not cleared.
// A stalled output register stops the back end; the queue then fills and s_axis_tready drops.
module printable_run_extractor import pre_pkg::*; #(
  parameter int unsigned MAX_MIN_LENGTH = MaxMinLengthDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [7:0]          s_axis_tdata,  // [7:0] byte_value
  input  logic                s_axis_tlast,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [7:0]          m_axis_tdata,  // [7:0] character
  output logic                m_axis_tuser,  // [0] kind
  output logic                m_axis_tlast
);

  cfg_wr_t cfg;
  cmd_t    push_cmd;
  cmd_t    pop_cmd;
  logic    push;
  logic    pop;
  logic    q_full;
  logic    q_empty;
  kind_e   kind;

  assign cfg.we   = cfg_we_i;
  assign cfg.idx  = cfg_idx_i;
  assign cfg.data = cfg_data_i;

  pre_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .byte_i     (s_axis_tdata),
    .eod_i      (s_axis_tlast),
    .q_full_i   (q_full),
    .cmd_push_o (push),
    .cmd_o      (push_cmd)
  );

  pre_cmd_fifo #(
    .Depth (CmdQDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_cmd),
    .full_o  (q_full),
    .pop_i   (pop),
    .data_o  (pop_cmd),
    .empty_o (q_empty)
  );

  pre_back #(
    .MAX_MIN_LENGTH (MAX_MIN_LENGTH)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg),
    .q_empty_i (q_empty),
    .q_pop_o   (pop),
    .cmd_i     (pop_cmd),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .m_kind_o  (kind),
    .m_char_o  (m_axis_tdata),
    .m_last_o  (m_axis_tlast)
  );

  assign m_axis_tuser = (kind == KindEnd);

endmodule

FILE: sim/tb_top.sv
// Self-checking testbench for the printable run extractor: stream stimulus, prediction and checks.
`timescale 1ns / 1ps

import pre_pkg::*;

typedef struct packed {
  kind_e      kind;
  logic [7:0] ch;
  logic       last;
} str_out_t;

class run_scoreboard;
  logic [7:0]  pending_chars [MaxMinLengthDef-1];
  int unsigned pending_cnt;
  bit          run_live;
  bit          phase_hi;
  logic [7:0]  low_byte;
  logic [4:0]  min_len;
  bit          wide;
  str_out_t    expected_q[$];
  int unsigned mismatches;

  function new();
    pending_cnt = 0;
    run_live = 1'b0;
    phase_hi = 1'b0;
    low_byte = 8'h00;
    min_len = MinLenReset;
    wide = 1'b0;
    mismatches = 0;
  endfunction

  function int unsigned eff_min();
    if (min_len == 0) return 1;
    if (min_len > MaxMinLengthDef) return MaxMinLengthDef;
    return min_len;
  endfunction

  function void push(kind_e k, logic [7:0] c);
    str_out_t r;
    r.kind = k;
    r.ch = c;
    r.last = 1'b0;
    expected_q.insert(expected_q.size(), r);
  endfunction

  function void release_pending();
    int unsigned i;
    for (i = 0; i < pending_cnt; i++) push(KindChar, pending_chars[i]);
    pending_cnt = 0;
  endfunction

  function void take_char(logic [7:0] c);
    if (run_live) begin
      push(KindChar, c);
    end else if (pending_cnt + 1 >= eff_min()) begin
      release_pending();
      run_live = 1'b1;
      push(KindChar, c);
    end else begin
      pending_chars[pending_cnt] = c;
      pending_cnt++;
    end
  endfunction

  function void close_run();
    if (!run_live && pending_cnt >= eff_min()) begin
      release_pending();
      run_live = 1'b1;
    end
    if (run_live) push(KindEnd, 8'h00);
    run_live = 1'b0;
    pending_cnt = 0;
  endfunction

  function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
    if (idx == RegMinLength) begin
      min_len = val;
    end else if (idx == RegWideMode) begin
      wide = val[0];
      phase_hi = 1'b0;
    end
  endfunction

  function void note_input(logic [7:0] b, logic eod);
    int unsigned q_len0;
    str_out_t    r;
    q_len0 = expected_q.size();
    if (!wide) begin
      if ((b >= PrintLo && b <= PrintHi) || b == TabChar) take_char(b);
      else close_run();
    end else if (!phase_hi) begin
      low_byte = b;
      phase_hi = 1'b1;
    end else begin
      phase_hi = 1'b0;
      if (b == 8'h00 && low_byte >= PrintLo && low_byte <= PrintHi) take_char(low_byte);
      else close_run();
    end
    if (eod) begin
      close_run();
      phase_hi = 1'b0;
    end
    if (expected_q.size() > q_len0) begin
      r = expected_q[expected_q.size() - 1];
      r.last = 1'b1;
      expected_q[expected_q.size() - 1] = r;
    end
  endfunction

  function void check_result(kind_e k, logic [7:0] c, logic last);
    str_out_t e;
    if (expected_q.size() == 0) begin
      $display("%0t: unexpected transaction, expected none, got kind=%0d char=%h last=%0d",
               $time, k, c, last);
      mismatches++;
      return;
    end
    e = expected_q.pop_front();
    if (k != e.kind) begin
      $display("%0t: kind mismatch, expected %0d, got %0d", $time, e.kind, k);
      mismatches++;
    end
    if (c !== e.ch) begin
      $display("%0t: character mismatch, expected %h, got %h", $time, e.ch, c);
      mismatches++;
    end
    if (last !== e.last) begin
      $display("%0t: last mismatch, expected %0d, got %0d", $time, e.last, last);
      mismatches++;
    end
  endfunction

  function int unsigned outstanding();
    return expected_q.size();
  endfunction
endclass

module tb_top;
  localparam int unsigned SettleCycles = 24;
  localparam int unsigned RxHoldCycles = 400;
  localparam int unsigned CycleLimit   = 600000;
  localparam int unsigned RandBytes    = 120;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [7:0]          s_axis_tdata;
  logic                s_axis_tlast;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [7:0]          m_axis_tdata;
  logic                m_axis_tuser;
  logic                m_axis_tlast;

  run_scoreboard sb = new();

  bit          tx_calm;
  bit          rx_calm;
  bit          rx_hold;
  int unsigned bytes_sent;
  int unsigned cycle_count;

  printable_run_extractor dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    cycle_count = 0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CycleLimit) begin
      $display("[printable_run_extractor] ERROR");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready) sb.note_input(s_axis_tdata, s_axis_tlast);
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      sb.check_result(kind_e'(m_axis_tuser), m_axis_tdata, m_axis_tlast);
  end

  initial begin : rx_proc
    int unsigned gap;
    m_axis_tready <= 1'b0;
    @(posedge rst_ni);
    @(posedge clk_i);
    forever begin
      if (rx_hold) begin
        gap = RxHoldCycles;
        rx_hold = 1'b0;
      end else begin
        gap = rx_calm ? 0 : $urandom_range(0, 12);
      end
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic eod);
    int unsigned gap;
    gap = tx_calm ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= b;
    s_axis_tlast <= eod;
    do @(posedge clk_i); while (!s_axis_tready);
    bytes_sent++;
  endtask

  task automatic settle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (sb.outstanding() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_cfg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    settle();
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.write_reg(idx, val);
    @(posedge clk_i);
  endtask

  task automatic send_text(input string s, input bit eod_last);
    int i;
    for (i = 0; i < s.len(); i++) send_byte(s[i], eod_last && i == s.len() - 1);
  endtask

  task automatic send_wide(input string s, input bit eod_last);
    int i;
    for (i = 0; i < s.len(); i++) begin
      send_byte(s[i], 1'b0);
      send_byte(8'h00, eod_last && i == s.len() - 1);
    end
  endtask

  function automatic logic [7:0] rand_print();
    if ($urandom_range(0, 9) == 0) return TabChar;
    return 8'($urandom_range(PrintLo, PrintHi));
  endfunction

  function automatic logic [7:0] rand_junk();
    logic [7:0] b;
    if ($urandom_range(0, 1) == 0) begin
      b = 8'($urandom_range(0, 8'h1F));
      if (b == TabChar) b = 8'h0B;
    end else begin
      b = 8'($urandom_range(8'h7F, 8'hFF));
    end
    return b;
  endfunction

  task automatic send_burst();
    int unsigned len;
    int unsigned i;
    bit          eod_on_char;
    bit          is_wide;
    is_wide = sb.wide;
    if ($urandom_range(0, 9) < 7) begin
      len = ($urandom_range(0, 4) == 0) ? $urandom_range(10, 20) : $urandom_range(0, 9);
      eod_on_char = (len > 0) && ($urandom_range(0, 4) == 0);
      for (i = 0; i < len; i++) begin
        if (is_wide) begin
          send_byte(8'($urandom_range(PrintLo, PrintHi)), 1'b0);
          send_byte(8'h00, eod_on_char && i == len - 1);
        end else begin
          send_byte(rand_print(), eod_on_char && i == len - 1);
        end
      end
      if (!eod_on_char) begin
        if (!is_wide) begin
          send_byte(rand_junk(), $urandom_range(0, 7) == 0);
        end else if ($urandom_range(0, 1) == 0) begin
          send_byte(rand_junk(), 1'b0);
          send_byte(8'h00, $urandom_range(0, 7) == 0);
        end else begin
          send_byte(8'($urandom_range(0, 255)), 1'b0);
          send_byte(8'($urandom_range(1, 255)), $urandom_range(0, 7) == 0);
        end
      end
    end else begin
      len = $urandom_range(1, 6);
      for (i = 0; i < len; i++) send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
    end
  endtask

  task automatic pick_setting();
    int unsigned sel;
    logic [4:0]  m;
    sel = $urandom_range(0, 11);
    case (sel)
      0: m = 5'd0;
      1: m = 5'd1;
      2: m = 5'd2;
      3: m = 5'd3;
      4: m = 5'd4;
      5: m = 5'd8;
      6: m = 5'd15;
      7: m = 5'd16;
      8: m = 5'd17;
      9: m = 5'd31;
      default: m = 5'($urandom_range(0, 31));
    endcase
    write_cfg(RegMinLength, m);
    write_cfg(RegWideMode, CfgDataW'($urandom_range(0, 1)));
    tx_calm = ($urandom_range(0, 3) == 0);
    rx_calm = ($urandom_range(0, 3) == 0);
  endtask

  initial begin : stim
    int unsigned i;
    int unsigned target;
    int unsigned errors;
    rst_ni <= 1'b0;
    cfg_we_i <= 1'b0;
    cfg_idx_i <= '0;
    cfg_data_i <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata <= 8'h00;
    s_axis_tlast <= 1'b0;
    tx_calm = 1'b0;
    rx_calm = 1'b0;
    rx_hold = 1'b0;
    bytes_sent = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: ASCII with a minimum of four.
    send_text("Ab\t~", 0);
    send_byte(8'h1F, 1'b0);
    send_text(" !", 0);
    send_byte(8'h7F, 1'b0);
    send_byte(8'h08, 1'b0);
    send_byte(8'h0A, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_text("QRST", 1);

    write_cfg(RegMinLength, 5'd0);
    send_text("a", 0);
    send_byte(8'h80, 1'b0);
    send_text("b", 1);

    write_cfg(RegMinLength, 5'd31);
    send_text("0123456789abcdef", 1);

    // Lower the minimum while characters are still held.
    write_cfg(RegMinLength, 5'd16);
    send_text("holdm", 0);
    write_cfg(RegMinLength, 5'd2);
    send_text("e", 0);
    send_byte(8'h00, 1'b0);
    write_cfg(RegMinLength, 5'd16);
    send_text("xyz", 0);
    write_cfg(RegMinLength, 5'd3);
    send_byte(8'h01, 1'b0);

    write_cfg(RegWideMode, 5'd1);
    write_cfg(RegMinLength, 5'd2);
    send_wide("H ~", 0);
    send_byte(8'h41, 1'b0);
    send_byte(8'h01, 1'b0);
    send_byte(8'h1F, 1'b0);
    send_byte(8'h00, 1'b0);
    send_wide("xy", 0);
    send_byte(8'h7A, 1'b1);
    send_byte(8'h70, 1'b0);
    write_cfg(RegWideMode, 5'd1);
    send_wide("qr", 1);

    // Receiver stalls for a long stretch while the sender keeps going.
    write_cfg(RegWideMode, 5'd0);
    write_cfg(RegMinLength, 5'd1);
    tx_calm = 1'b1;
    rx_hold = 1'b1;
    for (i = 0; i < 30; i++) send_byte(rand_print(), 1'b0);
    send_byte(8'h00, 1'b0);
    settle();
    tx_calm = 1'b0;

    target = bytes_sent + RandBytes;
    while (bytes_sent < target) begin
      pick_setting();
      repeat ($urandom_range(3, 8)) begin
        if (bytes_sent < target) send_burst();
      end
    end

    settle();
    errors = sb.mismatches;
    if (sb.outstanding() != 0) begin
      $display("%0t: %0d expected transactions never arrived", $time, sb.outstanding());
      errors++;
    end
    if (errors == 0) begin
      $display("[printable_run_extractor] OK");
    end else begin
      $display("[printable_run_extractor] ERROR");
    end
    $finish;
  end
endmodule
